// File: rtl/psrp_pkg.sv
// ----------------------------------------------------------------------------
// psrp_pkg
// Shared types, codes and color helpers for the pixel scale/rotate/palette
// writer: configuration bundle, job word passed front to back, palette.
// ----------------------------------------------------------------------------
package psrp_pkg;

    // coordinate width of a logical panel position (panels up to 8191 wide)
    localparam int COORD_W = 13;
    // signed width of an oriented source coordinate
    localparam int SRCC_W = 17;
    // signed width of a scaled Q16.16 position
    localparam int PROD_W = 42;
    // signed width of a rectangle edge in whole panel pixels
    localparam int RECT_W = 26;
    // fraction bits of the fixed-point scale and crop
    localparam int FRAC_W = 16;
    // squared color distance width
    localparam int DIST_W = 18;
    // job queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [2:0] REG_SCALE       = 3'd0;
    localparam logic [2:0] REG_CROP_X      = 3'd1;
    localparam logic [2:0] REG_CROP_Y      = 3'd2;
    localparam logic [2:0] REG_SOURCE_TURN = 3'd3;
    localparam logic [2:0] REG_PANEL_TURN  = 3'd4;
    localparam logic [2:0] REG_RAW_WIDTH   = 3'd5;
    localparam logic [2:0] REG_RAW_HEIGHT  = 3'd6;

    // source orientation codes
    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_ROT180 = 2'd1;
    localparam logic [1:0] SRC_EXIF6 = 2'd2;
    localparam logic [1:0] SRC_EXIF8 = 2'd3;

    // panel rotation codes
    localparam logic [1:0] PANEL_0   = 2'd0;
    localparam logic [1:0] PANEL_90  = 2'd1;
    localparam logic [1:0] PANEL_180 = 2'd2;
    localparam logic [1:0] PANEL_270 = 2'd3;

    // palette: panel code and whether each channel is full scale (else zero)
    localparam int PAL_N = 6;
    localparam logic [3:0] PAL_CODE [PAL_N] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6};
    localparam logic       PAL_R_ON [PAL_N] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    localparam logic       PAL_G_ON [PAL_N] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    localparam logic       PAL_B_ON [PAL_N] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    // configuration bundle
    typedef struct packed {
        logic [23:0] scale_q16;
        logic [31:0] crop_x_q16;
        logic [31:0] crop_y_q16;
        logic [1:0]  source_turn;
        logic [1:0]  panel_turn;
        logic [14:0] raw_width;
        logic [14:0] raw_height;
    } cfg_t;

    // clipped rectangle of logical panel pixels and its color
    typedef struct packed {
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] ys;
        logic [COORD_W-1:0] ye;
        logic [3:0]         color;
    } job_t;

    // 5-bit channel to 8 bits, floor(v * 255 / 31) = 8v + floor(7v / 31)
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [2:0] frac;
        frac = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
             + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
        return {v, 3'b000} + {5'b00000, frac};
    endfunction

    // 6-bit channel to 8 bits, floor(v * 255 / 63) = 4v + floor(v / 21)
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [1:0] frac;
        frac = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
        return {v, 2'b00} + {6'b000000, frac};
    endfunction

endpackage

// File: rtl/psrp_front.sv
// ----------------------------------------------------------------------------
// psrp_front
// Four-stage front: orients the source pixel, scales it to a panel
// rectangle, clips it to the logical panel and picks the palette color.
// Empty rectangles are dropped; the rest are pushed as jobs.
// ----------------------------------------------------------------------------
module psrp_front #(
    parameter int PANEL_WIDTH  = 1200,
    parameter int PANEL_HEIGHT = 1600,
    parameter int MAX_SPAN     = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  psrp_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [13:0]         src_x,
    input  logic [13:0]         src_y,
    input  logic [15:0]         pixel_rgb565,
    output logic                job_valid,
    input  logic                job_ready,
    output psrp_pkg::job_t      job
);

    localparam int SW = psrp_pkg::SRCC_W;
    localparam int PW = psrp_pkg::PROD_W;
    localparam int RW = psrp_pkg::RECT_W;
    localparam int CW = psrp_pkg::COORD_W;
    localparam int DW = psrp_pkg::DIST_W;
    localparam int NP = psrp_pkg::PAL_N;

    localparam logic signed [PW-1:0] CEIL_BIAS = PW'((1 << psrp_pkg::FRAC_W) - 1);
    localparam logic signed [RW-1:0] SPAN_MAX  = RW'(MAX_SPAN);
    localparam logic signed [RW-1:0] LW_WIDE   = RW'(PANEL_WIDTH);
    localparam logic signed [RW-1:0] LW_TALL   = RW'(PANEL_HEIGHT);

    // stage registers
    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [SW-1:0] s1_tx_reg, s1_ty_reg;
    logic [7:0]           s1_r_reg, s1_g_reg, s1_b_reg;
    logic signed [PW-1:0] s2_px_reg, s2_py_reg;
    logic [15:0]          s2_sq_reg [3];
    logic [15:0]          s2_cq_reg [3];
    logic signed [RW-1:0] s3_x0_reg, s3_x1_reg, s3_y0_reg, s3_y1_reg;
    logic [DW-1:0]        s3_dist_reg [NP];

    logic                 advance;
    logic                 s3_hit;

    // stage 0: undo source orientation, expand color
    logic signed [SW-1:0] sx, sy, rw, rh, tx_next, ty_next;

    assign sx = signed'(SW'(src_x));
    assign sy = signed'(SW'(src_y));
    assign rw = signed'(SW'(cfg.raw_width));
    assign rh = signed'(SW'(cfg.raw_height));

    always_comb
    begin
        case (cfg.source_turn)
            psrp_pkg::SRC_NONE:
            begin
                tx_next = sx;
                ty_next = sy;
            end
            psrp_pkg::SRC_ROT180:
            begin
                tx_next = rw - SW'(1) - sx;
                ty_next = rh - SW'(1) - sy;
            end
            psrp_pkg::SRC_EXIF6:
            begin
                tx_next = rh - SW'(1) - sy;
                ty_next = sx;
            end
            psrp_pkg::SRC_EXIF8:
            begin
                tx_next = sy;
                ty_next = rw - SW'(1) - sx;
            end
            default:
            begin
                tx_next = sx;
                ty_next = sy;
            end
        endcase
    end

    // stage 1: scale multiply and channel squares
    logic signed [PW-1:0] sc_w;
    logic signed [PW-1:0] px_next, py_next;
    logic [7:0]           ch [3];
    logic [7:0]           inv [3];

    assign sc_w    = signed'(PW'(cfg.scale_q16));
    assign px_next = PW'(s1_tx_reg) * sc_w;
    assign py_next = PW'(s1_ty_reg) * sc_w;
    assign ch[0]   = s1_r_reg;
    assign ch[1]   = s1_g_reg;
    assign ch[2]   = s1_b_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            inv[c] = 8'd255 - ch[c];
        end
    end

    // stage 2: floor/ceil edges, span limit, palette distances
    logic signed [PW-1:0] cx_w, cy_w, ax, bx, ay, by;
    logic signed [PW-1:0] fx0, fx1, fy0, fy1;
    logic signed [RW-1:0] x0, x1, y0, y1, x1_next, y1_next;
    logic [DW-1:0]        dist_next [NP];

    assign cx_w = signed'(PW'(cfg.crop_x_q16));
    assign cy_w = signed'(PW'(cfg.crop_y_q16));
    assign ax   = s2_px_reg - cx_w;
    assign bx   = s2_px_reg + sc_w - cx_w + CEIL_BIAS;
    assign ay   = s2_py_reg - cy_w;
    assign by   = s2_py_reg + sc_w - cy_w + CEIL_BIAS;
    assign fx0  = ax >>> psrp_pkg::FRAC_W;
    assign fx1  = bx >>> psrp_pkg::FRAC_W;
    assign fy0  = ay >>> psrp_pkg::FRAC_W;
    assign fy1  = by >>> psrp_pkg::FRAC_W;
    assign x0   = fx0[RW-1:0];
    assign x1   = fx1[RW-1:0];
    assign y0   = fy0[RW-1:0];
    assign y1   = fy1[RW-1:0];

    assign x1_next = ((x1 - x0) > SPAN_MAX) ? (x0 + SPAN_MAX) : x1;
    assign y1_next = ((y1 - y0) > SPAN_MAX) ? (y0 + SPAN_MAX) : y1;

    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            dist_next[i] = DW'(psrp_pkg::PAL_R_ON[i] ? s2_cq_reg[0] : s2_sq_reg[0])
                         + DW'(psrp_pkg::PAL_G_ON[i] ? s2_cq_reg[1] : s2_sq_reg[1])
                         + DW'(psrp_pkg::PAL_B_ON[i] ? s2_cq_reg[2] : s2_sq_reg[2]);
        end
    end

    // stage 3: clip to logical panel, nearest palette entry, first wins ties
    logic signed [RW-1:0] lw, lh, xs, xe, ys, ye;
    logic [DW-1:0]        best;
    logic [3:0]           code;

    assign lw = cfg.panel_turn[0] ? LW_TALL : LW_WIDE;
    assign lh = cfg.panel_turn[0] ? LW_WIDE : LW_TALL;
    assign xs = (s3_x0_reg < 0) ? '0 : s3_x0_reg;
    assign ys = (s3_y0_reg < 0) ? '0 : s3_y0_reg;
    assign xe = (s3_x1_reg > lw) ? lw : s3_x1_reg;
    assign ye = (s3_y1_reg > lh) ? lh : s3_y1_reg;
    assign s3_hit = (xe > xs) && (ye > ys);

    always_comb
    begin
        best = '1;
        code = psrp_pkg::PAL_CODE[1];
        for (int i = 0; i < NP; i++)
        begin
            if (s3_dist_reg[i] < best)
            begin
                best = s3_dist_reg[i];
                code = psrp_pkg::PAL_CODE[i];
            end
        end
    end

    assign job_valid = s3_valid_reg && s3_hit;
    assign job.xs    = xs[CW-1:0];
    assign job.xe    = xe[CW-1:0];
    assign job.ys    = ys[CW-1:0];
    assign job.ye    = ye[CW-1:0];
    assign job.color = code;

    // whole pipe moves together; an empty rectangle leaves without a push
    assign advance  = !s3_valid_reg || !s3_hit || job_ready;
    assign in_ready = advance;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_tx_reg <= tx_next;
            s1_ty_reg <= ty_next;
            s1_r_reg  <= psrp_pkg::expand5(pixel_rgb565[15:11]);
            s1_g_reg  <= psrp_pkg::expand6(pixel_rgb565[10:5]);
            s1_b_reg  <= psrp_pkg::expand5(pixel_rgb565[4:0]);

            s2_px_reg <= px_next;
            s2_py_reg <= py_next;
            for (int c = 0; c < 3; c++)
            begin
                s2_sq_reg[c] <= 16'(ch[c]) * 16'(ch[c]);
                s2_cq_reg[c] <= 16'(inv[c]) * 16'(inv[c]);
            end

            s3_x0_reg <= x0;
            s3_x1_reg <= x1_next;
            s3_y0_reg <= y0;
            s3_y1_reg <= y1_next;
            for (int i = 0; i < NP; i++)
            begin
                s3_dist_reg[i] <= dist_next[i];
            end
        end
    end

endmodule

// File: rtl/psrp_queue.sv
// ----------------------------------------------------------------------------
// psrp_queue
// Small job queue between front and back so that each side stalls on its
// own.
// ----------------------------------------------------------------------------
module psrp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  psrp_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output psrp_pkg::job_t pop_job
);

    localparam int DEPTH = psrp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    psrp_pkg::job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // job slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/psrp_back.sv
// ----------------------------------------------------------------------------
// psrp_back
// Walks a job rectangle in row-major order, rotates each logical pixel onto
// the panel and forms the nibble write in a registered output word.
// ----------------------------------------------------------------------------
module psrp_back #(
    parameter int PANEL_WIDTH  = 1200,
    parameter int PANEL_HEIGHT = 1600
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     panel_turn,
    input  logic           job_valid,
    output logic           job_ready,
    input  psrp_pkg::job_t job,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [19:0]    byte_address,
    output logic           low_nibble,
    output logic [3:0]     color_code,
    output logic           last
);

    localparam int CW       = psrp_pkg::COORD_W;
    localparam int IDX_BITS = $clog2(PANEL_WIDTH * PANEL_HEIGHT);
    localparam int IX_W     = (IDX_BITS > 21) ? IDX_BITS : 21;

    localparam logic [CW-1:0] PW_LAST = CW'(PANEL_WIDTH - 1);
    localparam logic [CW-1:0] PH_LAST = CW'(PANEL_HEIGHT - 1);

    // walker state
    logic           busy_reg;
    psrp_pkg::job_t job_reg;
    logic [CW-1:0]  emit_x_reg, emit_y_reg;

    // rotated pixel stage
    logic           b1_valid_reg;
    logic [CW-1:0]  b1_ox_reg, b1_oy_reg;
    logic [3:0]     b1_color_reg;
    logic           b1_last_reg;

    // output word
    logic           o_valid_reg;
    logic [19:0]    o_addr_reg;
    logic           o_low_reg;
    logic [3:0]     o_color_reg;
    logic           o_last_reg;

    logic           advance;
    logic           row_end, rect_end;
    logic [CW-1:0]  ox_next, oy_next;
    logic [IX_W-1:0] idx;

    assign advance   = !o_valid_reg || out_ready;
    assign job_ready = !busy_reg;
    assign row_end   = (emit_x_reg == job_reg.xe - CW'(1));
    assign rect_end  = row_end && (emit_y_reg == job_reg.ye - CW'(1));

    // logical to physical panel position
    always_comb
    begin
        case (panel_turn)
            psrp_pkg::PANEL_0:
            begin
                ox_next = emit_x_reg;
                oy_next = emit_y_reg;
            end
            psrp_pkg::PANEL_90:
            begin
                ox_next = emit_y_reg;
                oy_next = PH_LAST - emit_x_reg;
            end
            psrp_pkg::PANEL_180:
            begin
                ox_next = PW_LAST - emit_x_reg;
                oy_next = PH_LAST - emit_y_reg;
            end
            psrp_pkg::PANEL_270:
            begin
                ox_next = PW_LAST - emit_y_reg;
                oy_next = emit_x_reg;
            end
            default:
            begin
                ox_next = emit_x_reg;
                oy_next = emit_y_reg;
            end
        endcase
    end

    // pixel index in the frame buffer
    assign idx = IX_W'(b1_oy_reg) * IX_W'(PANEL_WIDTH) + IX_W'(b1_ox_reg);

    // walker and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            emit_x_reg   <= '0;
            emit_y_reg   <= '0;
            b1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!busy_reg)
            begin
                if (job_valid)
                begin
                    busy_reg   <= 1'b1;
                    emit_x_reg <= job.xs;
                    emit_y_reg <= job.ys;
                end
            end
            else if (advance)
            begin
                if (rect_end)
                begin
                    busy_reg <= 1'b0;
                end
                else if (row_end)
                begin
                    emit_x_reg <= job_reg.xs;
                    emit_y_reg <= emit_y_reg + CW'(1);
                end
                else
                begin
                    emit_x_reg <= emit_x_reg + CW'(1);
                end
            end
            if (advance)
            begin
                b1_valid_reg <= busy_reg;
                o_valid_reg  <= b1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!busy_reg && job_valid)
        begin
            job_reg <= job;
        end
        if (advance)
        begin
            b1_ox_reg    <= ox_next;
            b1_oy_reg    <= oy_next;
            b1_color_reg <= job_reg.color;
            b1_last_reg  <= rect_end;
            o_addr_reg   <= idx[20:1];
            o_low_reg    <= idx[0];
            o_color_reg  <= b1_color_reg;
            o_last_reg   <= b1_last_reg;
        end
    end

    assign out_valid    = o_valid_reg;
    assign byte_address = o_addr_reg;
    assign low_nibble   = o_low_reg;
    assign color_code   = o_color_reg;
    assign last         = o_last_reg;

endmodule

// File: rtl/pixel_scale_rotate_palette_pack_core.sv
// A pixel passes the front stage registers, a queue slot, the back walker and the
// rotated pixel and output word registers. Front takes one pixel per cycle while
// the 4-entry job queue has room. Back emits one write per cycle while the output
// is ready, loads each rectangle before its walk and takes the next one only when the walk is done.
// Reset (rst_n low, asynchronous) empties the pipe and queue and loads the
// register defaults: scale 1.0, no crop, no turns, raw size 1200 x 1600.
// ----------------------------------------------------------------------------
// pixel_scale_rotate_palette_pack_core
// Nearest-neighbor scale, rotate and palette quantize of a decoded pixel
// stream into nibble writes for a 4-bit packed panel frame buffer.
// ----------------------------------------------------------------------------
module pixel_scale_rotate_palette_pack_core #(
    parameter int PANEL_WIDTH  = 1200,
    parameter int PANEL_HEIGHT = 1600,
    parameter int MAX_SPAN     = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [31:0] cfg_wr_data,
    // pixel words in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // src_x[13:0], src_y[27:14], pixel_rgb565[43:28]
    // frame buffer writes out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // byte_address[19:0], low_nibble[20], color_code[24:21]
    output logic        m_axis_tlast
);

    psrp_pkg::cfg_t cfg_reg;
    psrp_pkg::job_t front_job, back_job;
    logic           front_valid, front_ready;
    logic           back_valid, back_ready;
    logic [19:0]    byte_address;
    logic           low_nibble;
    logic [3:0]     color_code;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_q16   <= 24'd65536;
            cfg_reg.crop_x_q16  <= '0;
            cfg_reg.crop_y_q16  <= '0;
            cfg_reg.source_turn <= psrp_pkg::SRC_NONE;
            cfg_reg.panel_turn  <= psrp_pkg::PANEL_0;
            cfg_reg.raw_width   <= 15'd1200;
            cfg_reg.raw_height  <= 15'd1600;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                psrp_pkg::REG_SCALE:       cfg_reg.scale_q16   <= cfg_wr_data[23:0];
                psrp_pkg::REG_CROP_X:      cfg_reg.crop_x_q16  <= cfg_wr_data;
                psrp_pkg::REG_CROP_Y:      cfg_reg.crop_y_q16  <= cfg_wr_data;
                psrp_pkg::REG_SOURCE_TURN: cfg_reg.source_turn <= cfg_wr_data[1:0];
                psrp_pkg::REG_PANEL_TURN:  cfg_reg.panel_turn  <= cfg_wr_data[1:0];
                psrp_pkg::REG_RAW_WIDTH:   cfg_reg.raw_width   <= cfg_wr_data[14:0];
                psrp_pkg::REG_RAW_HEIGHT:  cfg_reg.raw_height  <= cfg_wr_data[14:0];
                default:                   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // front: orient, scale, clip, quantize
    psrp_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .MAX_SPAN     (MAX_SPAN)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .src_x        (s_axis_tdata[13:0]),
        .src_y        (s_axis_tdata[27:14]),
        .pixel_rgb565 (s_axis_tdata[43:28]),
        .job_valid    (front_valid),
        .job_ready    (front_ready),
        .job          (front_job)
    );

    // job queue
    psrp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    // back: rectangle walk and nibble writes
    psrp_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .panel_turn   (cfg_reg.panel_turn),
        .job_valid    (back_valid),
        .job_ready    (back_ready),
        .job          (back_job),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .byte_address (byte_address),
        .low_nibble   (low_nibble),
        .color_code   (color_code),
        .last         (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0000000, color_code, low_nibble, byte_address};

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel scale/rotate/palette writer. Pixel words
// go in through bursts with random gaps or as a steady feed. Every accepted
// word is run through a local model of the scaling, orientation, palette and
// packing. The resulting nibble writes are then compared in order with what
// the block emits, while the output side stalls on its own random pattern.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PANEL_W       = 1200;
    localparam int PANEL_H       = 1600;
    localparam int SPAN_MAX      = 8;
    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 25;

    // panel color codes
    typedef enum logic [3:0] {
        COLOR_BLACK  = 4'd0,
        COLOR_WHITE  = 4'd1,
        COLOR_YELLOW = 4'd2,
        COLOR_RED    = 4'd3,
        COLOR_BLUE   = 4'd5,
        COLOR_GREEN  = 4'd6
    } panel_color_e;

    // palette in priority order, ties go to the earlier entry
    localparam int           PAL_R  [6] = '{0, 255, 255, 255, 0, 0};
    localparam int           PAL_G  [6] = '{0, 255, 255, 0, 0, 255};
    localparam int           PAL_B  [6] = '{0, 255, 0, 0, 255, 0};
    localparam panel_color_e PAL_ID [6] = '{COLOR_BLACK, COLOR_WHITE, COLOR_YELLOW,
                                            COLOR_RED, COLOR_BLUE, COLOR_GREEN};

    typedef struct {
        logic [19:0]  addr;
        logic         low_nib;
        panel_color_e code;
        logic         is_last;
    } fb_write_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [2:0]  cfg_wr_index  = '0;
    logic [31:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // src_x[13:0], src_y[27:14], pixel_rgb565[43:28]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // byte_address[19:0], low_nibble[20], color_code[24:21]
    logic        m_axis_tlast;

    fb_write_t      pending_writes[$];
    psrp_pkg::cfg_t model_cfg;
    int             errors       = 0;
    int             quiet_cycles = 0;
    int             burst_left   = 0;
    bit             steady_feed  = 1'b0;
    int             stall_mode   = 0;
    int             stall_run    = 0;

    pixel_scale_rotate_palette_pack_core #(
        .PANEL_WIDTH  (PANEL_W),
        .PANEL_HEIGHT (PANEL_H),
        .MAX_SPAN     (SPAN_MAX)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------

    // floor and ceiling of a Q16.16 value in whole pixels
    function automatic longint q16_floor(input longint v);
        return v >>> 16;
    endfunction

    function automatic longint q16_ceil(input longint v);
        return -((-v) >>> 16);
    endfunction

    // nearest palette entry by squared distance of the 8-bit expansion
    function automatic panel_color_e nearest_color(input logic [15:0] rgb);
        int r, g, b, d, best;
        panel_color_e pick;
        r = int'(rgb[15:11]) * 255 / 31;
        g = int'(rgb[10:5]) * 255 / 63;
        b = int'(rgb[4:0]) * 255 / 31;
        best = 32'h7fff_ffff;
        pick = COLOR_WHITE;
        for (int i = 0; i < 6; i++)
        begin
            d = (r - PAL_R[i]) * (r - PAL_R[i]) + (g - PAL_G[i]) * (g - PAL_G[i])
              + (b - PAL_B[i]) * (b - PAL_B[i]);
            if (d < best)
            begin
                best = d;
                pick = PAL_ID[i];
            end
        end
        return pick;
    endfunction

    // queue every nibble write that one source pixel causes
    function automatic void predict_writes(input logic [13:0] sx, input logic [13:0] sy,
                                           input logic [15:0] rgb);
        longint rw, rh, tx, ty, sc, x0, x1, y0, y1, lw, lh, ox, oy, pidx;
        panel_color_e code;
        fb_write_t held;
        bit have_held;
        rw = longint'(model_cfg.raw_width);
        rh = longint'(model_cfg.raw_height);
        sc = longint'(model_cfg.scale_q16);
        tx = longint'(sx);
        ty = longint'(sy);
        have_held = 1'b0;
        case (model_cfg.source_turn)
            psrp_pkg::SRC_ROT180:
            begin
                tx = rw - 1 - longint'(sx);
                ty = rh - 1 - longint'(sy);
            end
            psrp_pkg::SRC_EXIF6:
            begin
                tx = rh - 1 - longint'(sy);
                ty = longint'(sx);
            end
            psrp_pkg::SRC_EXIF8:
            begin
                tx = longint'(sy);
                ty = rw - 1 - longint'(sx);
            end
            default: ;
        endcase
        x0 = q16_floor(tx * sc - longint'(model_cfg.crop_x_q16));
        x1 = q16_ceil((tx + 1) * sc - longint'(model_cfg.crop_x_q16));
        y0 = q16_floor(ty * sc - longint'(model_cfg.crop_y_q16));
        y1 = q16_ceil((ty + 1) * sc - longint'(model_cfg.crop_y_q16));
        if (x1 - x0 > SPAN_MAX)
            x1 = x0 + SPAN_MAX;
        if (y1 - y0 > SPAN_MAX)
            y1 = y0 + SPAN_MAX;
        code = nearest_color(rgb);
        lw = model_cfg.panel_turn[0] ? PANEL_H : PANEL_W;
        lh = model_cfg.panel_turn[0] ? PANEL_W : PANEL_H;
        // row-major walk of the logical rectangle, last flag on the final write
        for (longint dy = y0; dy < y1; dy++)
        begin
            for (longint dx = x0; dx < x1; dx++)
            begin
                if (dx < 0 || dy < 0 || dx >= lw || dy >= lh)
                    continue;
                ox = dx;
                oy = dy;
                case (model_cfg.panel_turn)
                    psrp_pkg::PANEL_90:
                    begin
                        ox = dy;
                        oy = PANEL_H - 1 - dx;
                    end
                    psrp_pkg::PANEL_180:
                    begin
                        ox = PANEL_W - 1 - dx;
                        oy = PANEL_H - 1 - dy;
                    end
                    psrp_pkg::PANEL_270:
                    begin
                        ox = PANEL_W - 1 - dy;
                        oy = dx;
                    end
                    default: ;
                endcase
                if (ox < 0 || oy < 0 || ox >= PANEL_W || oy >= PANEL_H)
                    continue;
                if (have_held)
                    pending_writes.push_back(held);
                pidx = oy * PANEL_W + ox;
                held.addr    = 20'(pidx >>> 1);
                held.low_nib = pidx[0];
                held.code    = code;
                held.is_last = 1'b0;
                have_held    = 1'b1;
            end
        end
        if (have_held)
        begin
            held.is_last = 1'b1;
            pending_writes.push_back(held);
        end
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // compare each accepted write word with the oldest expected write
    always @(posedge clk)
    begin
        fb_write_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_writes.size() == 0)
                report_mismatch($sformatf("unexpected write word %h", m_axis_tdata));
            else
            begin
                want = pending_writes.pop_front();
                if (m_axis_tdata[19:0] !== want.addr)
                    report_mismatch($sformatf("byte_address %h, want %h",
                                              m_axis_tdata[19:0], want.addr));
                if (m_axis_tdata[20] !== want.low_nib)
                    report_mismatch($sformatf("low_nibble %b, want %b at %h",
                                              m_axis_tdata[20], want.low_nib, want.addr));
                if (m_axis_tdata[24:21] !== want.code)
                    report_mismatch($sformatf("color_code %0d, want %0d at %h",
                                              m_axis_tdata[24:21], want.code, want.addr));
                if (m_axis_tlast !== want.is_last)
                    report_mismatch($sformatf("tlast %b, want %b at %h",
                                              m_axis_tlast, want.is_last, want.addr));
            end
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // output side: stretches of always ready, light and heavy stalls
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(8, 64);
        end
        stall_run = stall_run - 1;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 7) != 0);
            2: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one pixel word; bursts of random length with random gaps unless the feed is steady
    task automatic send_pixel(input logic [13:0] sx, input logic [13:0] sy,
                              input logic [15:0] rgb);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, rgb, sy, sx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_writes(sx, sy, rgb);
        if (!steady_feed)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // stop feeding and wait for every expected write, optionally for the pipe too
    task automatic drain_writes(input bit settle);
        if (s_axis_tvalid)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        while (pending_writes.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, mirrored into the model
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            psrp_pkg::REG_SCALE:       model_cfg.scale_q16   = value[23:0];
            psrp_pkg::REG_CROP_X:      model_cfg.crop_x_q16  = value;
            psrp_pkg::REG_CROP_Y:      model_cfg.crop_y_q16  = value;
            psrp_pkg::REG_SOURCE_TURN: model_cfg.source_turn = value[1:0];
            psrp_pkg::REG_PANEL_TURN:  model_cfg.panel_turn  = value[1:0];
            psrp_pkg::REG_RAW_WIDTH:   model_cfg.raw_width   = value[14:0];
            psrp_pkg::REG_RAW_HEIGHT:  model_cfg.raw_height  = value[14:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input psrp_pkg::cfg_t c);
        write_reg(psrp_pkg::REG_SCALE, {8'h00, c.scale_q16});
        write_reg(psrp_pkg::REG_CROP_X, c.crop_x_q16);
        write_reg(psrp_pkg::REG_CROP_Y, c.crop_y_q16);
        write_reg(psrp_pkg::REG_SOURCE_TURN, {30'd0, c.source_turn});
        write_reg(psrp_pkg::REG_PANEL_TURN, {30'd0, c.panel_turn});
        write_reg(psrp_pkg::REG_RAW_WIDTH, {17'd0, c.raw_width});
        write_reg(psrp_pkg::REG_RAW_HEIGHT, {17'd0, c.raw_height});
    endtask

    // mostly panel-sized settings, now and then an extreme one
    function automatic psrp_pkg::cfg_t rand_config();
        psrp_pkg::cfg_t c;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            c.scale_q16 = 24'h010000;
        else if (pick < 7)
            c.scale_q16 = 24'($urandom_range(32'h4000, 32'h28000));
        else if (pick == 7)
            c.scale_q16 = 24'($urandom_range(32'h28000, 32'h90000));
        else if (pick == 8)
            c.scale_q16 = 24'($urandom);
        else
            c.scale_q16 = 24'($urandom_range(0, 32'h3fff));
        pick = $urandom_range(0, 9);
        c.crop_x_q16 = (pick < 6) ? 32'd0 : (pick < 9) ? $urandom_range(0, 32'h400000) : $urandom;
        pick = $urandom_range(0, 9);
        c.crop_y_q16 = (pick < 6) ? 32'd0 : (pick < 9) ? $urandom_range(0, 32'h400000) : $urandom;
        c.source_turn = 2'($urandom_range(0, 3));
        c.panel_turn  = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 5);
        if (pick < 2)
        begin
            c.raw_width  = 15'd1200;
            c.raw_height = 15'd1600;
        end
        else if (pick == 2)
        begin
            c.raw_width  = 15'd1600;
            c.raw_height = 15'd1200;
        end
        else if (pick < 5)
        begin
            c.raw_width  = 15'($urandom_range(1, 2000));
            c.raw_height = 15'($urandom_range(1, 2000));
        end
        else
        begin
            c.raw_width  = 15'($urandom_range(1, 16384));
            c.raw_height = 15'($urandom_range(1, 16384));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset settings: every palette color, the ties, panel corners and misses
    task automatic test_palette_and_bounds();
        send_pixel(14'd0, 14'd0, 16'h0000);
        send_pixel(14'd1199, 14'd1599, 16'hffff);
        send_pixel(14'd1, 14'd0, 16'hf800);
        send_pixel(14'd600, 14'd800, 16'hffe0);
        send_pixel(14'd2, 14'd0, 16'h001f);
        send_pixel(14'd3, 14'd0, 16'h07e0);
        // cyan and magenta sit at equal distance from several entries
        send_pixel(14'd4, 14'd0, 16'h07ff);
        send_pixel(14'd5, 14'd0, 16'hf81f);
        send_pixel(14'd1200, 14'd0, 16'($urandom));
        send_pixel(14'd0, 14'd1600, 16'($urandom));
        send_pixel(14'h3fff, 14'h3fff, 16'($urandom));
    endtask

    // each turned source orientation at the raw size extremes, one going negative
    task automatic test_source_turns();
        drain_writes(1'b1);
        write_reg(psrp_pkg::REG_RAW_WIDTH, 32'd1);
        write_reg(psrp_pkg::REG_RAW_HEIGHT, 32'd16384);
        write_reg(psrp_pkg::REG_SOURCE_TURN, {30'd0, psrp_pkg::SRC_ROT180});
        send_pixel(14'd0, 14'd16373, 16'h8410);
        send_pixel(14'd5, 14'd0, 16'hf800);
        drain_writes(1'b1);
        write_reg(psrp_pkg::REG_SOURCE_TURN, {30'd0, psrp_pkg::SRC_EXIF6});
        send_pixel(14'd3, 14'd16000, 16'h07e0);
        drain_writes(1'b1);
        write_reg(psrp_pkg::REG_SOURCE_TURN, {30'd0, psrp_pkg::SRC_EXIF8});
        send_pixel(14'd0, 14'd7, 16'h001f);
    endtask

    // each panel rotation with a 1.5 scale, edge spans partly off the panel
    task automatic test_panel_turns();
        drain_writes(1'b1);
        write_reg(psrp_pkg::REG_SOURCE_TURN, {30'd0, psrp_pkg::SRC_NONE});
        write_reg(psrp_pkg::REG_SCALE, 32'h0001_8000);
        write_reg(psrp_pkg::REG_PANEL_TURN, {30'd0, psrp_pkg::PANEL_90});
        send_pixel(14'd0, 14'd0, 16'hffe0);
        drain_writes(1'b1);
        write_reg(psrp_pkg::REG_PANEL_TURN, {30'd0, psrp_pkg::PANEL_180});
        send_pixel(14'd799, 14'd799, 16'hf800);
        drain_writes(1'b1);
        write_reg(psrp_pkg::REG_PANEL_TURN, {30'd0, psrp_pkg::PANEL_270});
        send_pixel(14'd1066, 14'd0, 16'h001f);
        send_pixel(14'd1200, 14'd900, 16'h0000);
        drain_writes(1'b1);
        write_reg(psrp_pkg::REG_PANEL_TURN, {30'd0, psrp_pkg::PANEL_0});
        send_pixel(14'd799, 14'd1066, 16'hffff);
    endtask

    // span saturation, empty rectangle, a crop that pushes edges negative and a crop off the panel
    task automatic test_span_limits();
        drain_writes(1'b1);
        write_reg(psrp_pkg::REG_SCALE, 32'h00ff_ffff);
        send_pixel(14'd1, 14'd1, 16'($urandom));
        drain_writes(1'b1);
        write_reg(psrp_pkg::REG_SCALE, 32'd0);
        send_pixel(14'd5, 14'd5, 16'($urandom));
        drain_writes(1'b1);
        write_reg(psrp_pkg::REG_SCALE, 32'h0005_0000);
        write_reg(psrp_pkg::REG_CROP_X, 32'h0003_0000);
        write_reg(psrp_pkg::REG_CROP_Y, 32'h0002_8000);
        send_pixel(14'd0, 14'd0, 16'($urandom));
        drain_writes(1'b1);
        write_reg(psrp_pkg::REG_SCALE, 32'h0001_0000);
        write_reg(psrp_pkg::REG_CROP_X, 32'hffff_ffff);
        write_reg(psrp_pkg::REG_CROP_Y, 32'hffff_ffff);
        send_pixel(14'd0, 14'd0, 16'($urandom));
    endtask

    // random settings per phase; pixels mostly inside the raw image
    task automatic test_random_phases();
        int rw, rh;
        for (int p = 0; p < PHASES; p++)
        begin
            drain_writes(1'b1);
            load_config(rand_config());
            rw = int'(model_cfg.raw_width);
            rh = int'(model_cfg.raw_height);
            steady_feed = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // hold the feed once until the output side has caught up
                if (p == PHASES / 2 && i == PHASE_ITEMS / 2)
                    drain_writes(1'b0);
                if ($urandom_range(0, 9) < 8)
                    send_pixel(14'($urandom_range(0, rw - 1)), 14'($urandom_range(0, rh - 1)),
                               16'($urandom));
                else
                    send_pixel(14'($urandom), 14'($urandom), 16'($urandom));
            end
            steady_feed = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        model_cfg.scale_q16   = 24'h010000;
        model_cfg.crop_x_q16  = 32'd0;
        model_cfg.crop_y_q16  = 32'd0;
        model_cfg.source_turn = psrp_pkg::SRC_NONE;
        model_cfg.panel_turn  = psrp_pkg::PANEL_0;
        model_cfg.raw_width   = 15'd1200;
        model_cfg.raw_height  = 15'd1600;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_palette_and_bounds();
        test_source_turns();
        test_panel_turns();
        test_span_limits();
        test_random_phases();

        drain_writes(1'b1);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
